[sv/q2rp_pkg.sv]
// Package for quaternion_to_roll_pitch: formats, arctangent table and helpers.
// No dependencies.
package q2rp_pkg;

  localparam int CordicStepsDefault    = 16;
  localparam int ComponentWidthDefault = 16;
  localparam int AtanTableLen          = 24;

  // Q2.14 operands, Q.28 products, CORDIC datapath with guard bits
  localparam int QW    = 16;
  localparam int TW    = 34;  // term width: |terms| < 2^33
  localparam int CW    = 37;  // CORDIC x/y width (gain 1.65, shifted operands)
  localparam int ZW    = 33;  // angle accumulator, 29 fraction bits, +-2pi
  localparam int SQW   = 29;  // square root result bits (c <= 2^28)
  localparam int RADW  = 58;  // radicand 2^56 - s^2

  localparam logic signed [ZW-1:0] PiQ29   = 33'sd1686629713;
  localparam logic signed [TW-1:0] OneQ28  = 34'sd268435456;
  localparam logic signed [15:0]   RollLim  = 16'sd25736;
  localparam logic signed [14:0]   PitchLim = 15'sd12868;

  function automatic logic signed [ZW-1:0] atan_q29(input int idx);
    logic signed [ZW-1:0] v;
    begin
      case (idx)
        0: v = 33'sd421657428;
        1: v = 33'sd248918915;
        2: v = 33'sd131521918;
        3: v = 33'sd66762579;
        4: v = 33'sd33510843;
        5: v = 33'sd16771758;
        6: v = 33'sd8387925;
        7: v = 33'sd4194219;
        8: v = 33'sd2097141;
        9: v = 33'sd1048575;
        default: v = (idx < AtanTableLen) ? (33'sd1 <<< (29 - idx)) : '0;
      endcase
      return v;
    end
  endfunction

  typedef struct packed {
    logic               vld;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_stage_t;

endpackage

[sv/q2rp_cordic.sv]
// Pipelined vectoring CORDIC, one iteration per register stage.
// Depends on q2rp_pkg. Side data (SW bits) rides along with each transaction.
module q2rp_cordic import q2rp_pkg::*; #(
  parameter int CordicSteps = CordicStepsDefault,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  cordic_stage_t        in_st,
  input  logic [SW-1:0]        in_side,
  output cordic_stage_t        out_st,
  output logic [SW-1:0]        out_side
);
  localparam int N = (CordicSteps > AtanTableLen) ? AtanTableLen : CordicSteps;

  cordic_stage_t      st   [N+1];
  logic [SW-1:0]      side [N+1];

  assign st[0]   = in_st;
  assign side[0] = in_side;

  for (genvar i = 0; i < N; i++) begin : g_step
    cordic_stage_t nx;
    // one micro-rotation toward y = 0
    always_comb begin
      nx.vld = st[i].vld;
      if (st[i].y >= 0) begin
        nx.x = st[i].x + (st[i].y >>> i);
        nx.y = st[i].y - (st[i].x >>> i);
        nx.z = st[i].z + atan_q29(i);
      end else begin
        nx.x = st[i].x - (st[i].y >>> i);
        nx.y = st[i].y + (st[i].x >>> i);
        nx.z = st[i].z - atan_q29(i);
      end
    end
    // advance when the pipe moves
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].vld <= 1'b0;
      end else if (en) begin
        st[i+1].vld <= nx.vld;
      end
      if (en) begin
        st[i+1].x    <= nx.x;
        st[i+1].y    <= nx.y;
        st[i+1].z    <= nx.z;
        side[i+1]    <= side[i];
      end
    end
  end

  assign out_st   = st[N];
  assign out_side = side[N];
endmodule

[sv/q2rp_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on q2rp_pkg. Side data rides along with each transaction.
module q2rp_sqrt import q2rp_pkg::*; #(
  parameter int SW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [RADW-1:0]   in_rad,
  input  logic [SW-1:0]     in_side,
  output logic              out_vld,
  output logic [SQW-1:0]    out_root,
  output logic [SW-1:0]     out_side
);
  localparam int NB = SQW;  // root bits, MSB first

  logic              vld  [NB+1];
  logic [RADW-1:0]   rem  [NB+1];
  logic [SQW-1:0]    root [NB+1];
  logic [SW-1:0]     side [NB+1];

  assign vld[0]  = in_vld;
  assign rem[0]  = in_rad;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar i = 0; i < NB; i++) begin : g_bit
    localparam int B = NB - 1 - i;
    logic [RADW+1:0] trial;
    logic [RADW+1:0] rem_w;
    logic            fits;
    // test (2r + 2^b) * 2^b against the remainder
    always_comb begin
      trial = ({{(RADW+2-SQW){1'b0}}, root[i]} << (B + 1))
            + ({{(RADW+1){1'b0}}, 1'b1} << (2 * B));
      rem_w = {2'b00, rem[i]};
      fits  = rem_w >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= fits ? RADW'(rem_w - trial) : rem[i];
        root[i+1] <= fits ? (root[i] | (SQW'(1) << B)) : root[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_vld  = vld[NB];
  assign out_root = root[NB];
  assign out_side = side[NB];
endmodule

[sv/quaternion_to_roll_pitch.sv]
// Quaternion to roll and pitch angles, deep pipeline.
// Register stages in order: align, products, terms, radicand, square root,
// CORDIC, round.
// Throughput: one transaction per cycle; the whole pipe stalls only while the
// output register is full and not taken. rst clears all valid bits.
// Depends on q2rp_pkg, q2rp_sqrt, q2rp_cordic.
module quaternion_to_roll_pitch import q2rp_pkg::*; #(
  parameter int CordicSteps    = CordicStepsDefault,
  parameter int ComponentWidth = ComponentWidthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ComponentWidth-1:0] quat_x,
  input  logic signed [ComponentWidth-1:0] quat_y,
  input  logic signed [ComponentWidth-1:0] quat_z,
  input  logic signed [ComponentWidth-1:0] quat_w,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [15:0]               roll_angle,
  output logic signed [14:0]               pitch_angle,
  output logic                             pitch_clamped
);
  // side data: roll zero, roll offset(2b: none,+pi,-pi), clamp, clamp sign, roll x,y,z
  localparam int RSW = 2 * CW + ZW + 5;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // align components to Q2.14
  function automatic logic signed [QW-1:0] align(input logic signed [ComponentWidth-1:0] v);
    logic signed [QW-1:0] r;
    begin
      if (ComponentWidth >= QW) r = QW'(v >>> (ComponentWidth - QW));
      else r = QW'(v) <<< (QW - ComponentWidth);
      return r;
    end
  endfunction

  // stage 1: aligned components
  logic v1;
  logic signed [QW-1:0] x1, y1, z1, w1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      x1 <= align(quat_x); y1 <= align(quat_y);
      z1 <= align(quat_z); w1 <= align(quat_w);
    end
  end

  // stage 2: products
  logic v2;
  logic signed [31:0] pwx, pyz, pxx, pyy, pwy, pzx;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      pwx <= w1 * x1; pyz <= y1 * z1; pxx <= x1 * x1;
      pyy <= y1 * y1; pwy <= w1 * y1; pzx <= z1 * x1;
    end
  end

  // stage 3: terms, roll preconditioning, pitch clamp test
  logic v3;
  logic signed [TW-1:0] a2, b2, s2;
  always_comb begin
    a2 = (TW'(pwx) + TW'(pyz)) <<< 1;
    b2 = OneQ28 - ((TW'(pxx) + TW'(pyy)) <<< 1);
    s2 = (TW'(pwy) - TW'(pzx)) <<< 1;
  end

  logic r3_zero, r3_pos, r3_neg, c3_clamp, c3_sign;
  logic signed [CW-1:0] rx3, ry3, sy3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      r3_zero  <= (a2 == 0) && (b2 == 0);
      r3_pos   <= (b2 < 0) && (a2 >= 0);
      r3_neg   <= (b2 < 0) && (a2 < 0);
      rx3      <= (b2 < 0) ? -CW'(b2) : CW'(b2);
      ry3      <= (b2 < 0) ? -CW'(a2) : CW'(a2);
      c3_clamp <= (s2 >= OneQ28) || (s2 <= -OneQ28);
      c3_sign  <= s2 > 0;
      sy3      <= CW'(s2);
    end
  end

  // stage 4: pitch radicand 2^56 - s^2; s fits SQW bits whenever it is not clamped
  logic v4;
  logic [RSW+CW-1:0] side3, side4;
  logic signed [SQW-1:0] sn3;
  logic signed [RADW-1:0] ssq;
  logic [RADW-1:0] rad4;
  assign side3 = {r3_zero, r3_pos, r3_neg, c3_clamp, c3_sign, rx3, ry3, ZW'(0), sy3};
  assign sn3   = SQW'(sy3);
  assign ssq   = sn3 * sn3;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      side4 <= side3;
      rad4  <= c3_clamp ? '0 : RADW'((RADW'(1) << 56) - ssq);
    end
  end

  // square root: cos = floor(sqrt(2^56 - s^2)); roll operands ride along
  logic sq_vld;
  logic [SQW-1:0] sq_root;
  logic [RSW+CW-1:0] sq_side;
  q2rp_sqrt #(.SW(RSW + CW)) u_sqrt (
    .clk, .rst, .en,
    .in_vld  (v4),
    .in_rad  (rad4),
    .in_side (side4),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_side(sq_side)
  );

  logic q_zero, q_pos, q_neg, q_clamp, q_sign;
  logic signed [CW-1:0] q_rx, q_ry, q_sy;
  logic signed [ZW-1:0] q_unused;
  assign {q_zero, q_pos, q_neg, q_clamp, q_sign, q_rx, q_ry, q_unused, q_sy} = sq_side;

  // two CORDIC pipes in lockstep: roll and pitch
  cordic_stage_t roll_in, roll_out, pit_in, pit_out;
  logic [4:0] flags_out;
  logic [4:0] pflags_unused;
  assign roll_in.vld = sq_vld;
  assign roll_in.x   = q_rx;
  assign roll_in.y   = q_ry;
  assign roll_in.z   = q_pos ? PiQ29 : (q_neg ? -PiQ29 : q_unused);
  assign pit_in.vld  = sq_vld;
  assign pit_in.x    = CW'(sq_root);
  assign pit_in.y    = q_sy;
  assign pit_in.z    = '0;

  q2rp_cordic #(.CordicSteps(CordicSteps), .SW(5)) u_roll (
    .clk, .rst, .en, .in_st(roll_in),
    .in_side({q_zero, q_pos, q_neg, q_clamp, q_sign}),
    .out_st(roll_out), .out_side(flags_out)
  );
  q2rp_cordic #(.CordicSteps(CordicSteps), .SW(5)) u_pitch (
    .clk, .rst, .en, .in_st(pit_in),
    .in_side(5'b0),
    .out_st(pit_out), .out_side(pflags_unused)
  );

  // round to Q3.13 roll and Q2.13 pitch and saturate; apply zero-roll and clamp flags
  logic signed [ZW-1:0] rr, pr;
  logic signed [15:0] roll_q;
  logic signed [14:0] pitch_q;
  always_comb begin
    rr = (roll_out.z + (ZW'(1) <<< 15)) >>> 16;
    pr = (pit_out.z + (ZW'(1) <<< 15)) >>> 16;
    if (flags_out[4]) roll_q = '0;
    else if (rr > ZW'(RollLim)) roll_q = RollLim;
    else if (rr < -ZW'(RollLim)) roll_q = -RollLim;
    else roll_q = 16'(rr);
    if (flags_out[1]) pitch_q = flags_out[0] ? PitchLim : -PitchLim;
    else if (pr > ZW'(PitchLim)) pitch_q = PitchLim;
    else if (pr < -ZW'(PitchLim)) pitch_q = -PitchLim;
    else pitch_q = 15'(pr);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= roll_out.vld;
    if (en) begin
      roll_angle    <= roll_q;
      pitch_angle   <= pitch_q;
      pitch_clamped <= flags_out[1];
    end
  end

  // both CORDIC pipes must stay aligned
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    roll_out.vld == pit_out.vld) else $error("cordic pipes out of step");
  // roll result stays within range
  a_roll_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= RollLim && roll_angle >= -RollLim))
    else $error("roll out of range");
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pitch_clamped) |-> (pitch_angle == PitchLim || pitch_angle == -PitchLim))
    else $error("clamped pitch not at limit");
  // a stall holds the valid flag and the roll result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(roll_angle)))
    else $error("result lost on stall");
endmodule
